[sv/sqrf_pkg.sv]
`default_nettype none
package sqrf_pkg;

    // width of a direction magnitude after normalization, values stay below 2^31
    localparam int V_BITS    = 31;
    // sum of three squared magnitudes
    localparam int N2_BITS   = 64;
    // integer square root of that sum
    localparam int ROOT_BITS = 32;

    // per-request side information that travels with the direction data
    typedef struct packed {
        logic       found;
        logic [1:0] idx;
        logic       degen;
        logic [2:0] neg;
    } t_side;

endpackage
`default_nettype wire

[sv/sqrf_turn.sv]
`default_nettype none
module sqrf_turn #(
    parameter int CB = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic signed [CB-1:0] i_c [4][3],
    output logic                 o_vld,
    output logic                 o_found,
    output logic [1:0]           o_idx,
    output logic signed [CB-1:0] o_p [3],
    output logic signed [CB:0]   o_d [3]
);
    localparam int PW = 2*CB;
    localparam int XW = 2*CB + 1;
    localparam int LW = 2*CB + 1;
    localparam int TW = 3*CB + 4;

    logic [6:1]            r_vld;
    logic signed [CB-1:0]  r1_c [4][3];
    logic signed [CB-1:0]  r2_c [4][3];
    logic signed [CB-1:0]  r3_c [4][3];
    logic signed [CB-1:0]  r4_c [4][3];
    logic signed [CB-1:0]  r5_c [4][3];
    logic signed [PW-1:0]  r2_ab [4][6];
    logic signed [XW-1:0]  r3_x [4][3];
    logic signed [LW-1:0]  r4_lo [4][3];
    logic signed [LW-1:0]  r4_hi [4][3];
    logic signed [TW-1:0]  r5_t [4];
    logic                  r6_found;
    logic [1:0]            r6_idx;
    logic signed [CB-1:0]  r6_p [3];
    logic signed [CB:0]    r6_d [3];

    logic [3:0] w_pos;
    logic [3:0] w_neg;
    logic [3:0] w_odd;
    logic [2:0] w_npos;
    logic [2:0] w_nneg;
    logic       w_found;
    logic [1:0] w_idx;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:1], i_vld};
        end
    end

    // triple product p . (prev x next), split over five stages
    always_ff @(posedge i_clk) begin
        r1_c <= i_c;
        r2_c <= r1_c;
        r3_c <= r2_c;
        r4_c <= r3_c;
        r5_c <= r4_c;
        for (int i = 0; i < 4; i++) begin
            r2_ab[i][0] <= PW'(r1_c[2'(i+3)][1]) * PW'(r1_c[2'(i+1)][2]);
            r2_ab[i][1] <= PW'(r1_c[2'(i+3)][2]) * PW'(r1_c[2'(i+1)][1]);
            r2_ab[i][2] <= PW'(r1_c[2'(i+3)][2]) * PW'(r1_c[2'(i+1)][0]);
            r2_ab[i][3] <= PW'(r1_c[2'(i+3)][0]) * PW'(r1_c[2'(i+1)][2]);
            r2_ab[i][4] <= PW'(r1_c[2'(i+3)][0]) * PW'(r1_c[2'(i+1)][1]);
            r2_ab[i][5] <= PW'(r1_c[2'(i+3)][1]) * PW'(r1_c[2'(i+1)][0]);
            for (int k = 0; k < 3; k++) begin
                r3_x[i][k]  <= XW'(r2_ab[i][2*k]) - XW'(r2_ab[i][2*k+1]);
                // cross component split in a low unsigned and a high signed half
                r4_lo[i][k] <= LW'(r3_c[i][k]) * LW'($signed({1'b0, r3_x[i][k][CB-1:0]}));
                r4_hi[i][k] <= LW'(r3_c[i][k]) * LW'($signed(r3_x[i][k][XW-1:CB]));
            end
            r5_t[i] <= (TW'(r4_hi[i][0]) <<< CB) + TW'(r4_lo[i][0])
                     + (TW'(r4_hi[i][1]) <<< CB) + TW'(r4_lo[i][1])
                     + (TW'(r4_hi[i][2]) <<< CB) + TW'(r4_lo[i][2]);
        end
    end

    // sign vote: the reflex corner is the single one that disagrees
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_neg[i] = r5_t[i][TW-1];
            w_pos[i] = (r5_t[i] != '0) && !r5_t[i][TW-1];
        end
        w_npos  = {2'b0, w_pos[0]} + {2'b0, w_pos[1]} + {2'b0, w_pos[2]} + {2'b0, w_pos[3]};
        w_nneg  = {2'b0, w_neg[0]} + {2'b0, w_neg[1]} + {2'b0, w_neg[2]} + {2'b0, w_neg[3]};
        w_found = (w_npos == 3'd3) || (w_nneg == 3'd3);
        w_odd   = (w_npos == 3'd3) ? ~w_pos : ~w_neg;
        w_idx   = w_found ? {w_odd[3] | w_odd[2], w_odd[3] | w_odd[1]} : 2'd0;
    end

    // pick reflex corner and opposite corner
    always_ff @(posedge i_clk) begin
        r6_found <= w_found;
        r6_idx   <= w_idx;
        for (int k = 0; k < 3; k++) begin
            r6_p[k] <= r5_c[w_idx][k];
            r6_d[k] <= (CB+1)'(r5_c[w_idx][k]) - (CB+1)'(r5_c[w_idx ^ 2'd2][k]);
        end
    end

    assign o_vld   = r_vld[6];
    assign o_found = r6_found;
    assign o_idx   = r6_idx;
    assign o_p     = r6_p;
    assign o_d     = r6_d;

endmodule
`default_nettype wire

[sv/sqrf_dir.sv]
`default_nettype none
module sqrf_dir #(
    parameter int CB = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  logic                              i_found,
    input  logic [1:0]                        i_idx,
    input  logic signed [CB-1:0]              i_p [3],
    input  logic signed [CB:0]                i_d [3],
    output logic                              o_vld,
    output sqrf_pkg::t_side                   o_side,
    output logic [sqrf_pkg::V_BITS-1:0]       o_v [3],
    output logic [sqrf_pkg::N2_BITS-1:0]      o_n2
);
    localparam int F   = CB - 2;
    localparam int DW  = 2*CB + 1;
    localparam int DPW = 2*CB + 3;
    localparam int LW  = 2*CB + 1;
    localparam int HW  = 2*CB + 3;
    localparam int WW  = 3*CB + 5;
    localparam int SB  = $clog2(WW);
    localparam int VB  = sqrf_pkg::V_BITS;
    localparam int N2  = sqrf_pkg::N2_BITS;
    localparam int NS  = 8 + SB;

    logic [NS-1:0]          r_vld;
    logic signed [DW-1:0]   r1_q [3];
    logic signed [CB-1:0]   r1_p [3];
    logic signed [CB-1:0]   r2_p [3];
    logic signed [CB:0]     r1_d [3];
    logic signed [CB:0]     r2_d [3];
    logic signed [CB:0]     r3_d [3];
    logic signed [DPW-1:0]  r2_dp;
    logic signed [LW-1:0]   r3_lo [3];
    logic signed [HW-1:0]   r3_hi [3];
    logic signed [WW-1:0]   r4_w [3];
    logic [WW-1:0]          r5_mag [3];
    logic [WW-1:0]          r_cur [SB+1];
    logic [WW-1:0]          r_sm [SB+1][3];
    logic [2*VB-1:0]        r_sq [3];
    logic [VB-1:0]          r_vq [3];
    logic [VB-1:0]          r_vo [3];
    logic [N2-1:0]          r_n2;
    sqrf_pkg::t_side        r1_sd, r2_sd, r3_sd, r4_sd, r5_sd;
    sqrf_pkg::t_side        r_ss [SB+1];
    sqrf_pkg::t_side        r_sqsd, r_osd;

    sqrf_pkg::t_side        w_sd0;
    sqrf_pkg::t_side        w_sd5;
    sqrf_pkg::t_side        w_sd6;
    logic [WW-1:0]          w_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NS-2:0], i_vld};
        end
    end

    always_comb begin
        w_sd0       = '0;
        w_sd0.found = i_found;
        w_sd0.idx   = i_idx;
        w_sd5       = r4_sd;
        for (int k = 0; k < 3; k++) begin
            w_sd5.neg[k] = r4_w[k][WW-1];
        end
        // largest magnitude
        w_m = r5_mag[0];
        if (r5_mag[1] > w_m) w_m = r5_mag[1];
        if (r5_mag[2] > w_m) w_m = r5_mag[2];
        w_sd6       = r5_sd;
        w_sd6.degen = r5_sd.found && (w_m == '0);
    end

    // w = d * 2^(2F) - p * (d . p), then magnitudes
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r1_q[k]  <= DW'(i_d[k]) * DW'(i_p[k]);
            r3_lo[k] <= LW'(r2_p[k]) * LW'($signed({1'b0, r2_dp[CB-1:0]}));
            r3_hi[k] <= HW'(r2_p[k]) * HW'($signed(r2_dp[DPW-1:CB]));
            r4_w[k]  <= (WW'(r3_d[k]) <<< (2*F)) - ((WW'(r3_hi[k]) <<< CB) + WW'(r3_lo[k]));
            r5_mag[k] <= r4_w[k][WW-1] ? WW'(-r4_w[k]) : WW'(r4_w[k]);
        end
        r1_p  <= i_p;
        r1_d  <= i_d;
        r1_sd <= w_sd0;
        r2_dp <= DPW'(r1_q[0]) + DPW'(r1_q[1]) + DPW'(r1_q[2]);
        r2_p  <= r1_p;
        r2_d  <= r1_d;
        r2_sd <= r1_sd;
        r3_d  <= r2_d;
        r3_sd <= r2_sd;
        r4_sd <= r3_sd;
        r5_sd <= w_sd5;
        r_cur[0] <= w_m;
        r_sm[0]  <= r5_mag;
        r_ss[0]  <= w_sd6;
    end

    // normalizing shift, one shift-amount bit per stage from the top
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < SB; j++) begin
            if ((r_cur[j] >> (1 << (SB-1-j))) >= (WW'(1) << (VB-1))) begin
                r_cur[j+1] <= r_cur[j] >> (1 << (SB-1-j));
                for (int k = 0; k < 3; k++) begin
                    r_sm[j+1][k] <= r_sm[j][k] >> (1 << (SB-1-j));
                end
            end else begin
                r_cur[j+1] <= r_cur[j];
                r_sm[j+1]  <= r_sm[j];
            end
            r_ss[j+1] <= r_ss[j];
        end
    end

    // squares and their sum
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_sq[k] <= (2*VB)'(r_sm[SB][k][VB-1:0]) * (2*VB)'(r_sm[SB][k][VB-1:0]);
            r_vq[k] <= r_sm[SB][k][VB-1:0];
        end
        r_sqsd <= r_ss[SB];
        r_n2   <= N2'(r_sq[0]) + N2'(r_sq[1]) + N2'(r_sq[2]);
        r_vo   <= r_vq;
        r_osd  <= r_sqsd;
    end

    assign o_vld  = r_vld[NS-1];
    assign o_side = r_osd;
    assign o_v    = r_vo;
    assign o_n2   = r_n2;

endmodule
`default_nettype wire

[sv/sqrf_isqrt.sv]
`default_nettype none
module sqrf_isqrt #(
    parameter int SIDE_W = 100
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic [sqrf_pkg::N2_BITS-1:0]        i_x,
    input  logic [SIDE_W-1:0]                   i_side,
    output logic                                o_vld,
    output logic [sqrf_pkg::ROOT_BITS-1:0]      o_root,
    output logic [SIDE_W-1:0]                   o_side
);
    localparam int N2  = sqrf_pkg::N2_BITS;
    localparam int NST = sqrf_pkg::ROOT_BITS;

    logic [NST-1:0]    r_vld;
    logic [N2-1:0]     r_x [NST];
    logic [N2-1:0]     r_res [NST];
    logic [SIDE_W-1:0] r_side [NST];

    logic [N2-1:0]     c_x [NST+1];
    logic [N2-1:0]     c_res [NST+1];
    logic [SIDE_W-1:0] c_side [NST+1];
    logic [N2-1:0]     n_x [NST];
    logic [N2-1:0]     n_res [NST];
    logic [N2-1:0]     w_bit [NST];
    logic [N2-1:0]     w_try [NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NST-2:0], i_vld};
        end
    end

    // one root bit per stage
    always_comb begin
        c_x[0]    = i_x;
        c_res[0]  = '0;
        c_side[0] = i_side;
        for (int j = 0; j < NST; j++) begin
            c_x[j+1]    = r_x[j];
            c_res[j+1]  = r_res[j];
            c_side[j+1] = r_side[j];
        end
        for (int j = 0; j < NST; j++) begin
            w_bit[j] = N2'(1) << (N2 - 2 - 2*j);
            w_try[j] = c_res[j] + w_bit[j];
            if (c_x[j] >= w_try[j]) begin
                n_x[j]   = c_x[j] - w_try[j];
                n_res[j] = (c_res[j] >> 1) + w_bit[j];
            end else begin
                n_x[j]   = c_x[j];
                n_res[j] = c_res[j] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NST; j++) begin
            r_x[j]    <= n_x[j];
            r_res[j]  <= n_res[j];
            r_side[j] <= c_side[j];
        end
    end

    assign o_vld  = r_vld[NST-1];
    assign o_root = r_res[NST-1][NST-1:0];
    assign o_side = r_side[NST-1];

endmodule
`default_nettype wire

[sv/sqrf_div.sv]
`default_nettype none
module sqrf_div #(
    parameter int FB = 14
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_vld,
    input  logic [sqrf_pkg::ROOT_BITS-1:0]  i_n,
    input  logic [sqrf_pkg::V_BITS-1:0]     i_v [3],
    input  sqrf_pkg::t_side                 i_side,
    output logic                            o_vld,
    output logic [FB:0]                     o_q [3],
    output sqrf_pkg::t_side                 o_side
);
    localparam int RB = sqrf_pkg::ROOT_BITS;
    localparam int VB = sqrf_pkg::V_BITS;
    localparam int NW = VB + FB + 1;
    localparam int ND = FB + 1;

    logic [ND:0]            r_vld;
    logic [RB-1:0]          r0_n;
    logic [RB-1:0]          r0_r [3];
    logic [FB:0]            r0_l [3];
    sqrf_pkg::t_side        r0_sd;
    logic [RB-1:0]          r_n [ND];
    logic [RB-1:0]          r_r [ND][3];
    logic [FB:0]            r_l [ND][3];
    logic [FB:0]            r_q [ND][3];
    sqrf_pkg::t_side        r_sd [ND];

    logic [RB-1:0]          w_nn;
    logic [NW-1:0]          w_num [3];
    logic [RB-1:0]          c_n [ND];
    logic [RB-1:0]          c_r [ND][3];
    logic [FB:0]            c_l [ND][3];
    logic [FB:0]            c_q [ND][3];
    sqrf_pkg::t_side        c_sd [ND];
    logic [RB:0]            w_t [ND][3];
    logic                   w_ge [ND][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ND-1:0], i_vld};
        end
    end

    // numerator v * 2^FB + n/2, high part becomes the first remainder
    always_comb begin
        w_nn = (i_n == '0) ? RB'(1) : i_n;
        for (int k = 0; k < 3; k++) begin
            w_num[k] = (NW'(i_v[k]) << FB) + NW'(w_nn >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        r0_n  <= w_nn;
        r0_sd <= i_side;
        for (int k = 0; k < 3; k++) begin
            r0_r[k] <= RB'(w_num[k] >> (FB+1));
            r0_l[k] <= w_num[k][FB:0];
        end
    end

    // restoring division, one quotient bit per stage
    always_comb begin
        c_n[0]  = r0_n;
        c_sd[0] = r0_sd;
        for (int k = 0; k < 3; k++) begin
            c_r[0][k] = r0_r[k];
            c_l[0][k] = r0_l[k];
            c_q[0][k] = '0;
        end
        for (int j = 1; j < ND; j++) begin
            c_n[j]  = r_n[j-1];
            c_sd[j] = r_sd[j-1];
            c_r[j]  = r_r[j-1];
            c_l[j]  = r_l[j-1];
            c_q[j]  = r_q[j-1];
        end
        for (int j = 0; j < ND; j++) begin
            for (int k = 0; k < 3; k++) begin
                w_t[j][k]  = {c_r[j][k], c_l[j][k][FB]};
                w_ge[j][k] = w_t[j][k] >= {1'b0, c_n[j]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < ND; j++) begin
            r_n[j]  <= c_n[j];
            r_sd[j] <= c_sd[j];
            for (int k = 0; k < 3; k++) begin
                r_r[j][k] <= w_ge[j][k] ? RB'(w_t[j][k] - {1'b0, c_n[j]}) : RB'(w_t[j][k]);
                r_l[j][k] <= c_l[j][k] << 1;
                r_q[j][k] <= {c_q[j][k][FB-1:0], w_ge[j][k]};
            end
        end
    end

    assign o_vld  = r_vld[ND];
    assign o_q    = r_q[ND-1];
    assign o_side = r_sd[ND-1];

endmodule
`default_nettype wire

[sv/spherical_quad_reflex_finder.sv]
// The 32-stage square root and the divider with one quotient bit per stage make up
//   most of the pipeline from start to o_valid.
// Throughput: one request per cycle; busy is always low and results cannot be held off.
// Reset: synchronous active-low i_rst_n clears every stage valid bit; data is not reset.
`default_nettype none
module spherical_quad_reflex_finder #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_corner0_x,
    input  logic signed [COORD_BITS-1:0] i_corner0_y,
    input  logic signed [COORD_BITS-1:0] i_corner0_z,
    input  logic signed [COORD_BITS-1:0] i_corner1_x,
    input  logic signed [COORD_BITS-1:0] i_corner1_y,
    input  logic signed [COORD_BITS-1:0] i_corner1_z,
    input  logic signed [COORD_BITS-1:0] i_corner2_x,
    input  logic signed [COORD_BITS-1:0] i_corner2_y,
    input  logic signed [COORD_BITS-1:0] i_corner2_z,
    input  logic signed [COORD_BITS-1:0] i_corner3_x,
    input  logic signed [COORD_BITS-1:0] i_corner3_y,
    input  logic signed [COORD_BITS-1:0] i_corner3_z,
    output logic                         o_valid,
    output logic                         o_reflex_found,
    output logic [1:0]                   o_reflex_corner,
    output logic signed [COORD_BITS-1:0] o_slide_x,
    output logic signed [COORD_BITS-1:0] o_slide_y,
    output logic signed [COORD_BITS-1:0] o_slide_z,
    output logic                         o_degenerate
);
    localparam int CB     = COORD_BITS;
    localparam int FB     = COORD_BITS - 2;
    localparam int VB     = sqrf_pkg::V_BITS;
    localparam int SDW    = $bits(sqrf_pkg::t_side);
    localparam int SIDE_W = SDW + 3*VB;

    logic signed [CB-1:0]              w_c [4][3];
    logic                              w_t_vld, w_t_found;
    logic [1:0]                        w_t_idx;
    logic signed [CB-1:0]              w_t_p [3];
    logic signed [CB:0]                w_t_d [3];
    logic                              w_d_vld;
    sqrf_pkg::t_side                   w_d_sd;
    logic [VB-1:0]                     w_d_v [3];
    logic [sqrf_pkg::N2_BITS-1:0]      w_d_n2;
    logic [SIDE_W-1:0]                 w_s_in, w_s_out;
    logic                              w_s_vld;
    logic [sqrf_pkg::ROOT_BITS-1:0]    w_s_root;
    sqrf_pkg::t_side                   w_s_sd;
    logic [VB-1:0]                     w_s_v [3];
    logic                              w_q_vld;
    logic [FB:0]                       w_q [3];
    sqrf_pkg::t_side                   w_q_sd;

    logic                              r_valid;
    logic                              r_found;
    logic [1:0]                        r_idx;
    logic                              r_degen;
    logic signed [CB-1:0]              r_slide [3];

    // the pipeline takes a request every cycle
    assign busy = 1'b0;

    assign w_c[0][0] = i_corner0_x;
    assign w_c[0][1] = i_corner0_y;
    assign w_c[0][2] = i_corner0_z;
    assign w_c[1][0] = i_corner1_x;
    assign w_c[1][1] = i_corner1_y;
    assign w_c[1][2] = i_corner1_z;
    assign w_c[2][0] = i_corner2_x;
    assign w_c[2][1] = i_corner2_y;
    assign w_c[2][2] = i_corner2_z;
    assign w_c[3][0] = i_corner3_x;
    assign w_c[3][1] = i_corner3_y;
    assign w_c[3][2] = i_corner3_z;

    sqrf_turn #(.CB(CB)) u_turn (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_c     (w_c),
        .o_vld   (w_t_vld),
        .o_found (w_t_found),
        .o_idx   (w_t_idx),
        .o_p     (w_t_p),
        .o_d     (w_t_d)
    );

    sqrf_dir #(.CB(CB)) u_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_t_vld),
        .i_found (w_t_found),
        .i_idx   (w_t_idx),
        .i_p     (w_t_p),
        .i_d     (w_t_d),
        .o_vld   (w_d_vld),
        .o_side  (w_d_sd),
        .o_v     (w_d_v),
        .o_n2    (w_d_n2)
    );

    // side data and magnitudes ride along the square root
    assign w_s_in = {w_d_sd, w_d_v[0], w_d_v[1], w_d_v[2]};

    sqrf_isqrt #(.SIDE_W(SIDE_W)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_d_vld),
        .i_x     (w_d_n2),
        .i_side  (w_s_in),
        .o_vld   (w_s_vld),
        .o_root  (w_s_root),
        .o_side  (w_s_out)
    );

    assign w_s_sd   = w_s_out[SIDE_W-1 -: SDW];
    assign w_s_v[0] = w_s_out[3*VB-1 -: VB];
    assign w_s_v[1] = w_s_out[2*VB-1 -: VB];
    assign w_s_v[2] = w_s_out[VB-1:0];

    sqrf_div #(.FB(FB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_s_vld),
        .i_n     (w_s_root),
        .i_v     (w_s_v),
        .i_side  (w_s_sd),
        .o_vld   (w_q_vld),
        .o_q     (w_q),
        .o_side  (w_q_sd)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_q_vld;
        end
    end

    // apply signs, zero the direction when none exists
    always_ff @(posedge i_clk) begin
        r_found <= w_q_sd.found;
        r_idx   <= w_q_sd.idx;
        r_degen <= w_q_sd.degen;
        for (int k = 0; k < 3; k++) begin
            if (w_q_sd.found && !w_q_sd.degen) begin
                r_slide[k] <= w_q_sd.neg[k] ? -CB'(w_q[k]) : CB'(w_q[k]);
            end else begin
                r_slide[k] <= '0;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_reflex_found  = r_found;
    assign o_reflex_corner = r_idx;
    assign o_slide_x       = r_slide[0];
    assign o_slide_y       = r_slide[1];
    assign o_slide_z       = r_slide[2];
    assign o_degenerate    = r_degen;

endmodule
`default_nettype wire

[sim/spherical_quad_reflex_finder_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module spherical_quad_reflex_finder_tb;

    localparam int CB       = 16;
    localparam int FRAC     = CB - 2;
    localparam int LIMIT    = 2000000;
    localparam int N_RANDOM = 900;

    typedef logic [11:0][CB-1:0] quad_t;

    typedef struct packed {
        logic          found;
        logic [1:0]    corner;
        logic [CB-1:0] sx;
        logic [CB-1:0] sy;
        logic [CB-1:0] sz;
        logic          degen;
    } reflex_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    quad_t       drv_quad = '0;
    logic        o_valid;
    logic        o_reflex_found;
    logic [1:0]  o_reflex_corner;
    logic signed [CB-1:0] o_slide_x, o_slide_y, o_slide_z;
    logic        o_degenerate;

    quad_t   pending_quads[$];
    reflex_t expected_reflex[$];
    int      n_errors = 0;
    int      n_taken = 0;
    int      cycles = 0;
    logic    took = 1'b0;

    spherical_quad_reflex_finder #(.COORD_BITS(CB)) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_corner0_x     (drv_quad[0]),
        .i_corner0_y     (drv_quad[1]),
        .i_corner0_z     (drv_quad[2]),
        .i_corner1_x     (drv_quad[3]),
        .i_corner1_y     (drv_quad[4]),
        .i_corner1_z     (drv_quad[5]),
        .i_corner2_x     (drv_quad[6]),
        .i_corner2_y     (drv_quad[7]),
        .i_corner2_z     (drv_quad[8]),
        .i_corner3_x     (drv_quad[9]),
        .i_corner3_y     (drv_quad[10]),
        .i_corner3_z     (drv_quad[11]),
        .o_valid         (o_valid),
        .o_reflex_found  (o_reflex_found),
        .o_reflex_corner (o_reflex_corner),
        .o_slide_x       (o_slide_x),
        .o_slide_y       (o_slide_y),
        .o_slide_z       (o_slide_z),
        .o_degenerate    (o_degenerate)
    );

    always #10 i_clk = ~i_clk;

    // append one quad to the pending list
    task automatic add_quad(input quad_t q);
        pending_quads.insert(pending_quads.size(), q);
    endtask

    // floor square root, bit by bit
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // reflex corner and slide direction for one quad
    function automatic reflex_t find_reflex(input quad_t q);
        logic signed [127:0] c[4][3];
        logic signed [127:0] a0, a1, a2, b0, b1, b2, crx, cry, crz, tp, dp;
        logic signed [127:0] d[3], w[3];
        logic [127:0] mag[3], m;
        logic [63:0] v[3], n2, n, r;
        int sgn[4];
        int npos, nneg, idx, s;
        reflex_t res;
        res = '0;
        npos = 0;
        nneg = 0;
        idx = -1;
        for (int i = 0; i < 4; i++)
            for (int k = 0; k < 3; k++)
                c[i][k] = $signed(q[i*3+k]);
        // turn sign of each corner: p . (prev x next)
        for (int i = 0; i < 4; i++) begin
            a0 = c[(i+3)&3][0]; a1 = c[(i+3)&3][1]; a2 = c[(i+3)&3][2];
            b0 = c[(i+1)&3][0]; b1 = c[(i+1)&3][1]; b2 = c[(i+1)&3][2];
            crx = a1*b2 - a2*b1;
            cry = a2*b0 - a0*b2;
            crz = a0*b1 - a1*b0;
            tp = c[i][0]*crx + c[i][1]*cry + c[i][2]*crz;
            sgn[i] = (tp < 0) ? -1 : (tp == 0) ? 0 : 1;
            npos += (sgn[i] > 0);
            nneg += (sgn[i] < 0);
        end
        if (npos == 3) begin
            idx = 0;
            for (int i = 1; i < 4; i++) if (sgn[i] < sgn[idx]) idx = i;
        end else if (nneg == 3) begin
            idx = 0;
            for (int i = 1; i < 4; i++) if (sgn[i] > sgn[idx]) idx = i;
        end
        if (idx < 0) return res;
        res.found = 1'b1;
        res.corner = idx[1:0];
        // w = d * 2^2F - p * (d . p), d = p - opposite
        for (int k = 0; k < 3; k++) d[k] = c[idx][k] - c[(idx+2)&3][k];
        dp = d[0]*c[idx][0] + d[1]*c[idx][1] + d[2]*c[idx][2];
        m = 0;
        for (int k = 0; k < 3; k++) begin
            w[k] = (d[k] <<< (2*FRAC)) - c[idx][k]*dp;
            mag[k] = (w[k] < 0) ? -w[k] : w[k];
            if (mag[k] > m) m = mag[k];
        end
        if (m == 0) begin
            res.degen = 1'b1;
            return res;
        end
        s = 0;
        while (m >= (128'd1 << 31)) begin
            m = m >> 1;
            s++;
        end
        n2 = 0;
        for (int k = 0; k < 3; k++) begin
            v[k] = 64'(mag[k] >> s);
            n2 = n2 + v[k]*v[k];
        end
        n = floor_sqrt(n2);
        if (n == 0) n = 1;
        for (int k = 0; k < 3; k++) begin
            r = ((v[k] << FRAC) + (n >> 1)) / n;
            if (r > (64'd1 << (CB-1)) - 1) r = (64'd1 << (CB-1)) - 1;
            if (w[k] < 0) r = -r;
            if (k == 0) res.sx = r[CB-1:0];
            else if (k == 1) res.sy = r[CB-1:0];
            else res.sz = r[CB-1:0];
        end
        return res;
    endfunction

    function automatic quad_t make_quad(input int v[12]);
        quad_t q;
        for (int i = 0; i < 12; i++) q[i] = v[i][CB-1:0];
        return q;
    endfunction

    // corners scattered around a point near the sphere, in random order
    function automatic quad_t near_patch();
        quad_t q;
        int ax, sg, spread, u, vv;
        ax = $urandom_range(0, 2);
        sg = $urandom_range(0, 1) ? 1 : -1;
        spread = $urandom_range(0, 1) ? 12000 : 2000;
        for (int i = 0; i < 4; i++) begin
            u = $urandom_range(0, 2*spread) - spread;
            vv = $urandom_range(0, 2*spread) - spread;
            q[i*3 + ax]         = 16'(sg * (16384 + $urandom_range(0, 64) - 32));
            q[i*3 + (ax+1)%3]   = 16'(u);
            q[i*3 + (ax+2)%3]   = 16'(vv);
        end
        // zero-length edge now and then
        if ($urandom_range(0, 15) == 0) begin
            int j;
            j = $urandom_range(0, 3);
            for (int k = 0; k < 3; k++) q[((j+1)&3)*3+k] = q[j*3+k];
        end
        return q;
    endfunction

    // sender: one request per accept, idle rate set by progress
    always @(negedge i_clk) begin
        int idle_pct;
        idle_pct = (n_taken < 300) ? 36 : (n_taken < 600) ? 83 : 0;
        if (!(start && !took)) begin
            if (pending_quads.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                drv_quad <= pending_quads.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // accept requests and check results
    always @(posedge i_clk) begin
        reflex_t got, want;
        cycles <= cycles + 1;
        took <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) begin
            expected_reflex.insert(expected_reflex.size(), find_reflex(drv_quad));
            n_taken <= n_taken + 1;
        end
        if (i_rst_n && o_valid) begin
            got = {o_reflex_found, o_reflex_corner, o_slide_x, o_slide_y, o_slide_z,
                   o_degenerate};
            if (expected_reflex.size() == 0) begin
                n_errors <= n_errors + 1;
                if (n_errors < 10) $display("unexpected result %h", got);
            end else begin
                want = expected_reflex.pop_front();
                if (got !== want) begin
                    n_errors <= n_errors + 1;
                    if (n_errors < 10)
                        $display("mismatch: found %b/%b corner %0d/%0d x %h/%h y %h/%h z %h/%h degen %b/%b",
                                 want.found, got.found, want.corner, got.corner,
                                 want.sx, got.sx, want.sy, got.sy, want.sz, got.sz,
                                 want.degen, got.degen);
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int v[12];
        // directed: extremes, convex and bent quads, zero edges, off-sphere
        add_quad('0);
        add_quad({12{16'h7fff}});
        add_quad({12{16'h8000}});
        for (int i = 0; i < 12; i++) v[i] = (i % 2) ? -32768 : 32767;
        add_quad(make_quad(v));
        v = '{4000, 4000, 15000, -4000, 4000, 15000, -4000, -4000, 15000, 4000, -4000, 15000};
        add_quad(make_quad(v));
        v = '{4000, 4000, 15000, 0, 0, 15000, -4000, -4000, 15000, 4000, -4000, 15000};
        add_quad(make_quad(v));
        v = '{6000, 0, 15000, 500, 500, 16000, 0, 6000, 15000, -6000, -6000, 14000};
        add_quad(make_quad(v));
        v = '{6000, 0, 15000, -6000, -6000, 14000, 0, 6000, 15000, 500, 500, 16000};
        add_quad(make_quad(v));
        v = '{0, 0, 16384, 0, 0, 16384, -4000, -4000, 15000, 4000, -4000, 15000};
        add_quad(make_quad(v));
        v = '{0, 0, 16384, 3000, 200, 16000, 0, 0, 8192, 200, 3000, 16000};
        add_quad(make_quad(v));
        v = '{-32768, 32767, 0, 32767, -32768, 1, 0, 0, -32768, 1, 1, 32767};
        add_quad(make_quad(v));
        for (int j = 0; j < 10; j++) add_quad(near_patch());
        // release reset on a falling edge
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // hold off until the pipe drains once
        wait (pending_quads.size() == 0 && !start && expected_reflex.size() == 0);
        repeat (80) @(posedge i_clk);
        for (int j = 0; j < N_RANDOM; j++) begin
            if ($urandom_range(0, 3) == 0) begin
                quad_t q;
                for (int i = 0; i < 12; i++) q[i] = 16'($urandom);
                add_quad(q);
            end else begin
                add_quad(near_patch());
            end
        end
        wait (pending_quads.size() == 0 && !start && expected_reflex.size() == 0);
        repeat (100) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

[spherical_quad_reflex_finder.f]
sv/sqrf_pkg.sv
sv/sqrf_turn.sv
sv/sqrf_dir.sv
sv/sqrf_isqrt.sv
sv/sqrf_div.sv
sv/spherical_quad_reflex_finder.sv
sim/spherical_quad_reflex_finder_tb.sv
